// ----- rtl/ir_pulse_distance_frame_encoder_assert.svh -----
// Assertion macros used by the frame encoder's slot sequencer.
// Expects i_clk and i_rst_n in the scope of the including module.
`ifndef IR_PULSE_DISTANCE_FRAME_ENCODER_ASSERT_SVH
`define IR_PULSE_DISTANCE_FRAME_ENCODER_ASSERT_SVH

// same-cycle implication
`define IRPD_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("irpd: same-cycle check failed");

// next-cycle implication
`define IRPD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("irpd: next-cycle check failed");

`endif

// ----- rtl/irpd_pkg.sv -----
// Types, constants and register defaults for the IR pulse-distance frame encoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package irpd_pkg;

    localparam int MAX_PREFIX_BITS   = 16;
    localparam int MAX_COMMAND_BITS  = 15;
    localparam int TOGGLE_PLAIN_BITS = 4;

    localparam int CMD_W      = 15;
    localparam int LEN_W      = 4;
    localparam int REP_W      = 8;
    localparam int US_W       = 16;
    localparam int FT_W       = 23;
    localparam int CNT_W      = 5;
    localparam int SEQ_W      = 16;
    localparam int NUM_SEQ    = 4;
    localparam int NUM_SLOTS  = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [FT_W-1:0] FRAME_TIME_MAX = '1;

    // frame slots in transmit order
    localparam logic [2:0] SLOT_HDR  = 3'd0;
    localparam logic [2:0] SLOT_RPT  = 3'd1;
    localparam logic [2:0] SLOT_SEQ0 = 3'd2;
    localparam logic [2:0] SLOT_SEQ3 = 3'd5;
    localparam logic [2:0] SLOT_TRL  = 3'd6;

    // bit order of a sequence segment
    localparam logic [1:0] ORD_PLAIN  = 2'd0;
    localparam logic [1:0] ORD_REV    = 2'd1;
    localparam logic [1:0] ORD_INVREV = 2'd2;
    localparam logic [1:0] ORD_TOGGLE = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ZERO   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OPT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PREFIX = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SUFFIX = 3'd6;

    // option bits
    localparam int OPT_HDR      = 0;
    localparam int OPT_TRL      = 1;
    localparam int OPT_RPT      = 2;
    localparam int OPT_RPT_HDR  = 3;
    localparam int OPT_HEADLESS = 4;
    localparam int OPT_TOGGLE   = 5;

    localparam logic [1:0] FMT_NEC = 2'd0;
    localparam logic [1:0] FMT_EXT = 2'd1;

    typedef struct packed {
        logic [31:0] zero_timing;
        logic [31:0] one_timing;
        logic [31:0] header_timing;
        logic [31:0] repeat_timing;
        logic [23:0] options;
        logic [20:0] prefix_code;
        logic [20:0] suffix_code;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        zero_timing:   32'h0230_0230,
        one_timing:    32'h0230_0690,
        header_timing: 32'h2328_1194,
        repeat_timing: 32'h2328_08CA,
        options:       24'h02_3007,
        prefix_code:   21'h08_0000,
        suffix_code:   21'h00_0000
    };

    typedef struct packed {
        logic [SEQ_W-1:0] bits;
        logic [CNT_W-1:0] cnt;
        logic [1:0]       order;
    } t_seg;

    typedef struct packed {
        t_seg [NUM_SEQ-1:0] seq;
        logic               hdr;
        logic               rpt;
        logic               trl;
    } t_plan;

    typedef struct packed {
        logic [US_W-1:0] mark;
        logic [US_W-1:0] space;
        logic            last;
    } t_pair;

endpackage
`default_nettype wire

// ----- rtl/irpd_if.sv -----
// Handshake channels of the frame encoder: command in, pair out, register write.
// Depends on irpd_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface irpd_cmd_if;
    import irpd_pkg::*;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command_bits;
    logic [LEN_W-1:0] command_length;
    logic [REP_W-1:0] repetition;
    modport source (output valid, command_bits, command_length, repetition, input ready);
    modport sink   (input valid, command_bits, command_length, repetition, output ready);
endinterface

interface irpd_pair_if;
    import irpd_pkg::*;
    logic            valid;
    logic            ready;
    logic [US_W-1:0] mark_us;
    logic [US_W-1:0] space_us;
    logic            last;
    logic [FT_W-1:0] frame_time_us;
    modport source (output valid, mark_us, space_us, last, frame_time_us, input ready);
    modport sink   (input valid, mark_us, space_us, last, frame_time_us, output ready);
endinterface

interface irpd_cfg_if;
    import irpd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/irpd_cfg.sv -----
// Configuration register file of the frame encoder.
// Depends on irpd_pkg and irpd_if.
`timescale 1ns / 1ps
`default_nettype none
module irpd_cfg (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    irpd_cfg_if.sink       i_cfg,
    output irpd_pkg::t_cfg o_cfg
);
    import irpd_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_ZERO:   r_cfg.zero_timing   <= i_cfg.data;
                REG_ONE:    r_cfg.one_timing    <= i_cfg.data;
                REG_HEADER: r_cfg.header_timing <= i_cfg.data;
                REG_REPEAT: r_cfg.repeat_timing <= i_cfg.data;
                REG_OPT:    r_cfg.options       <= i_cfg.data[23:0];
                REG_PREFIX: r_cfg.prefix_code   <= i_cfg.data[20:0];
                REG_SUFFIX: r_cfg.suffix_code   <= i_cfg.data[20:0];
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/irpd_plan.sv -----
// Frame planner: picks the frame kind and lays out its slots and bit segments.
// Depends on irpd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module irpd_plan (
    input  wire irpd_pkg::t_cfg              i_cfg,
    input  wire logic [irpd_pkg::CMD_W-1:0]  i_command_bits,
    input  wire logic [irpd_pkg::LEN_W-1:0]  i_command_length,
    input  wire logic [irpd_pkg::REP_W-1:0]  i_repetition,
    output irpd_pkg::t_plan                  o_plan
);
    import irpd_pkg::*;

    function automatic t_seg mk_seg(logic [SEQ_W-1:0] bits, logic [CNT_W-1:0] cnt,
                                    logic [1:0] order);
        t_seg s;
        s.bits  = bits;
        s.cnt   = cnt;
        s.order = order;
        return s;
    endfunction

    logic [23:0]      opts;
    logic [1:0]       fmt;
    logic             rep_nz;
    logic [SEQ_W-1:0] pbits, sbits, cbits;
    logic [CNT_W-1:0] pcnt, scnt, clen, clen_raw;

    always_comb begin
        opts     = i_cfg.options;
        fmt      = opts[7:6];
        rep_nz   = (i_repetition != '0);
        pbits    = i_cfg.prefix_code[15:0];
        sbits    = i_cfg.suffix_code[15:0];
        cbits    = {1'b0, i_command_bits};
        pcnt     = (i_cfg.prefix_code[20:16] > CNT_W'(MAX_PREFIX_BITS)) ?
                   CNT_W'(MAX_PREFIX_BITS) : i_cfg.prefix_code[20:16];
        scnt     = (i_cfg.suffix_code[20:16] > CNT_W'(MAX_PREFIX_BITS)) ?
                   CNT_W'(MAX_PREFIX_BITS) : i_cfg.suffix_code[20:16];
        clen_raw = {1'b0, i_command_length};
        clen     = (clen_raw > CNT_W'(MAX_COMMAND_BITS)) ? CNT_W'(MAX_COMMAND_BITS) : clen_raw;

        o_plan = '0;
        if (opts[OPT_RPT] && rep_nz) begin
            o_plan.hdr = opts[OPT_RPT_HDR] && opts[OPT_HDR];
            o_plan.rpt = 1'b1;
        end else if (opts[OPT_HEADLESS] && rep_nz) begin
            o_plan.seq[0] = mk_seg(pbits, pcnt, ORD_PLAIN);
            o_plan.seq[1] = mk_seg(cbits, clen, ORD_PLAIN);
            o_plan.seq[2] = mk_seg(sbits, scnt, ORD_PLAIN);
        end else if (opts[OPT_TOGGLE] && i_repetition[0]) begin
            o_plan.seq[0] = mk_seg(cbits, clen, ORD_TOGGLE);
        end else begin
            o_plan.hdr = opts[OPT_HDR];
            if (fmt == FMT_NEC) begin
                o_plan.seq[0] = mk_seg(pbits, pcnt, ORD_REV);
                o_plan.seq[1] = mk_seg(pbits, pcnt, ORD_INVREV);
                o_plan.seq[2] = mk_seg(cbits, clen, ORD_REV);
                o_plan.seq[3] = mk_seg(cbits, clen, ORD_INVREV);
            end else if (fmt == FMT_EXT) begin
                o_plan.seq[0] = mk_seg(pbits, pcnt, ORD_REV);
                o_plan.seq[1] = mk_seg(cbits, clen, ORD_REV);
                o_plan.seq[2] = mk_seg(cbits, clen, ORD_INVREV);
            end else begin
                o_plan.seq[0] = mk_seg(pbits, pcnt, ORD_PLAIN);
                o_plan.seq[1] = mk_seg(cbits, clen, ORD_PLAIN);
                o_plan.seq[2] = mk_seg(sbits, scnt, ORD_PLAIN);
            end
        end
        // every frame kind ends with the optional trailer mark
        o_plan.trl = opts[OPT_TRL];
    end

endmodule
`default_nettype wire

// ----- rtl/irpd_seq.sv -----
// Slot sequencer: walks the planned slots, one mark/space pair per cycle while i_load_ok is high.
// Depends on irpd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "ir_pulse_distance_frame_encoder_assert.svh"
module irpd_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire irpd_pkg::t_cfg  i_cfg,
    input  wire logic            i_cmd_vld,
    output logic                 o_cmd_rdy,
    input  wire irpd_pkg::t_plan i_plan,
    output logic                 o_pair_vld,
    output irpd_pkg::t_pair      o_pair,
    input  wire logic            i_load_ok
);
    import irpd_pkg::*;

    function automatic logic [NUM_SLOTS-1:0][CNT_W-1:0] plan_lens(t_plan p);
        logic [NUM_SLOTS-1:0][CNT_W-1:0] l;
        l           = '0;
        l[SLOT_HDR] = {{(CNT_W-1){1'b0}}, p.hdr};
        l[SLOT_RPT] = {{(CNT_W-1){1'b0}}, p.rpt};
        l[SLOT_TRL] = {{(CNT_W-1){1'b0}}, p.trl};
        for (int i = 0; i < NUM_SEQ; i++) begin
            l[int'(SLOT_SEQ0) + i] = p.seq[i].cnt;
        end
        return l;
    endfunction

    // lowest nonempty slot at or above 'from'; msb flags a hit
    function automatic logic [3:0] find_slot(logic [NUM_SLOTS-1:0] ne, logic [3:0] from);
        logic [3:0] res;
        res = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (ne[i] && (4'(i) >= from)) res = {1'b1, 3'(i)};
        end
        return res;
    endfunction

    logic                            r_busy;
    logic [2:0]                      r_slot;
    logic [CNT_W-1:0]                r_k;
    t_plan                           r_plan;

    logic [NUM_SLOTS-1:0][CNT_W-1:0] lens, lens_in;
    logic [NUM_SLOTS-1:0]            ne, ne_in;
    logic [CNT_W-1:0]                len_cur, pos;
    logic [3:0]                      first, nxt;
    logic [2:0]                      slot_rel;
    t_seg                            seg;
    logic                            acc_in, advance, at_end, bit_val;

    always_comb begin
        lens    = plan_lens(r_plan);
        lens_in = plan_lens(i_plan);
        for (int i = 0; i < NUM_SLOTS; i++) begin
            ne[i]    = (lens[i] != '0);
            ne_in[i] = (lens_in[i] != '0);
        end
        len_cur = lens[r_slot];
        first   = find_slot(ne_in, 4'd0);
        nxt     = find_slot(ne, {1'b0, r_slot} + 4'd1);
        at_end  = (r_k == len_cur - CNT_W'(1));

        acc_in  = i_cmd_vld && !r_busy;
        advance = r_busy && i_load_ok;

        slot_rel = r_slot - SLOT_SEQ0;
        seg      = r_plan.seq[slot_rel[1:0]];
        pos      = (seg.order == ORD_REV || seg.order == ORD_INVREV) ?
                   (seg.cnt - CNT_W'(1) - r_k) : r_k;
        bit_val  = seg.bits[pos[3:0]];
        if (seg.order == ORD_INVREV) begin
            bit_val = !bit_val;
        end else if (seg.order == ORD_TOGGLE && r_k >= CNT_W'(TOGGLE_PLAIN_BITS)) begin
            bit_val = !bit_val;
        end

        o_pair.last = at_end && !nxt[3];
        unique case (r_slot) inside
            SLOT_HDR: begin
                o_pair.mark  = i_cfg.header_timing[31:16];
                o_pair.space = i_cfg.header_timing[15:0];
            end
            SLOT_RPT: begin
                o_pair.mark  = i_cfg.repeat_timing[31:16];
                o_pair.space = i_cfg.repeat_timing[15:0];
            end
            [SLOT_SEQ0:SLOT_SEQ3]: begin
                o_pair.mark  = bit_val ? i_cfg.one_timing[31:16] : i_cfg.zero_timing[31:16];
                o_pair.space = bit_val ? i_cfg.one_timing[15:0]  : i_cfg.zero_timing[15:0];
            end
            SLOT_TRL: begin
                o_pair.mark  = i_cfg.options[23:8];
                o_pair.space = '0;
            end
            default: begin
                o_pair.mark  = '0;
                o_pair.space = '0;
            end
        endcase
    end

    assign o_cmd_rdy  = !r_busy;
    assign o_pair_vld = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_slot <= SLOT_HDR;
            r_k    <= '0;
        end else if (acc_in) begin
            r_busy <= first[3];
            r_slot <= first[2:0];
            r_k    <= '0;
        end else if (advance) begin
            if (at_end) begin
                r_k <= '0;
                if (nxt[3]) r_slot <= nxt[2:0];
                else        r_busy <= 1'b0;
            end else begin
                r_k <= r_k + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) r_plan <= i_plan;
    end

    `IRPD_ASSERT_IMPL(a_k_in_range, r_busy, r_k < len_cur)
    `IRPD_ASSERT_IMPL(a_slot_nonempty, r_busy, ne[r_slot])
    `IRPD_ASSERT_NEXT(a_last_ends_frame, advance && o_pair.last, !r_busy)
    `IRPD_ASSERT_NEXT(a_accept_starts, acc_in && (|ne_in), r_busy && r_k == '0)

endmodule
`default_nettype wire

// ----- rtl/irpd_acc.sv -----
// Output stage: frame time accumulator and result register.
// Depends on irpd_pkg and irpd_if.
`timescale 1ns / 1ps
`default_nettype none
module irpd_acc (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_pair_vld,
    input  wire irpd_pkg::t_pair i_pair,
    output logic                 o_load_ok,
    irpd_pair_if.source          o_out
);
    import irpd_pkg::*;

    logic            r_vld;
    logic [FT_W-1:0] r_total;
    logic [US_W-1:0] r_mark, r_space;
    logic            r_last;
    logic [FT_W-1:0] r_time;

    logic            load;
    logic [FT_W:0]   sum;
    logic [FT_W-1:0] sat;

    always_comb begin
        o_load_ok = !r_vld || o_out.ready;
        load      = i_pair_vld && o_load_ok;
        sum       = {1'b0, r_total} + (FT_W + 1)'(i_pair.mark) + (FT_W + 1)'(i_pair.space);
        sat       = (sum > {1'b0, FRAME_TIME_MAX}) ? FRAME_TIME_MAX : sum[FT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= 1'b0;
            r_total <= '0;
        end else begin
            if (load)             r_vld <= 1'b1;
            else if (o_out.ready) r_vld <= 1'b0;
            // running sum restarts after the final pair
            if (load) r_total <= i_pair.last ? '0 : sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_mark  <= i_pair.mark;
            r_space <= i_pair.space;
            r_last  <= i_pair.last;
            r_time  <= i_pair.last ? sat : '0;
        end
    end

    assign o_out.valid         = r_vld;
    assign o_out.mark_us       = r_mark;
    assign o_out.space_us      = r_space;
    assign o_out.last          = r_last;
    assign o_out.frame_time_us = r_time;

endmodule
`default_nettype wire

// ----- rtl/ir_pulse_distance_frame_encoder.sv -----
// Channel   Dir  Beat                         Payload
// i_cmd     in   valid & ready                command_bits, command_length, repetition
// o_pair    out  valid & ready                mark_us, space_us, last, frame_time_us
// i_cfg     in   valid & ready (always ready) index, data
//
// A command beat is taken when the sequencer is idle; a frame of N pairs then
// occupies the sequencer until its last pair is loaded, one pair per cycle
// unless o_pair stalls; only then is the next command beat taken. N is at most
// 64. A frame with nothing to send produces no beat and frees the sequencer at once.
// The output register stalls the sequencer while a pair waits on o_pair.
// Reset is synchronous, active low, and restores the register defaults.
// Top level; depends on irpd_pkg, irpd_if, irpd_cfg, irpd_plan, irpd_seq, irpd_acc.
`timescale 1ns / 1ps
`default_nettype none
module ir_pulse_distance_frame_encoder (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    irpd_cmd_if.sink    i_cmd,
    irpd_pair_if.source o_pair,
    irpd_cfg_if.sink    i_cfg
);
    import irpd_pkg::*;

    t_cfg  cfg;
    t_plan plan;
    t_pair pair;
    logic  pair_vld;
    logic  load_ok;
    logic  cmd_rdy;

    irpd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    irpd_plan u_plan (
        .i_cfg            (cfg),
        .i_command_bits   (i_cmd.command_bits),
        .i_command_length (i_cmd.command_length),
        .i_repetition     (i_cmd.repetition),
        .o_plan           (plan)
    );

    irpd_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_cmd_vld  (i_cmd.valid),
        .o_cmd_rdy  (cmd_rdy),
        .i_plan     (plan),
        .o_pair_vld (pair_vld),
        .o_pair     (pair),
        .i_load_ok  (load_ok)
    );

    irpd_acc u_acc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pair_vld (pair_vld),
        .i_pair     (pair),
        .o_load_ok  (load_ok),
        .o_out      (o_pair)
    );

    assign i_cmd.ready = cmd_rdy;

endmodule
`default_nettype wire

// ----- sim/ir_pulse_distance_frame_encoder_test.sv -----
// Self-checking bench for the IR pulse-distance frame encoder: directed frames, then random ones.
// It predicts each frame's mark/space pairs and checks every pair beat in order.
// Depends on irpd_pkg, irpd_if and the ir_pulse_distance_frame_encoder RTL.
`timescale 1ns / 1ps
module ir_pulse_distance_frame_encoder_test;
    import irpd_pkg::*;

    localparam int    IDLE_LIMIT = 3000;
    localparam int    DRAIN_GAP  = 8;
    localparam logic [1:0] FMT_RAW   = 2'd2;
    localparam logic [1:0] FMT_RAW_B = 2'd3;

    typedef struct {
        logic [CMD_W-1:0] bits;
        logic [LEN_W-1:0] len;
        logic [REP_W-1:0] rep;
    } t_cmd;

    typedef struct {
        logic [US_W-1:0] mark;
        logic [US_W-1:0] space;
        logic            last;
        logic [FT_W-1:0] ftime;
    } t_pulse;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    irpd_cmd_if  cmd_ch ();
    irpd_pair_if pair_ch ();
    irpd_cfg_if  cfg_ch ();

    ir_pulse_distance_frame_encoder i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_ch),
        .o_pair (pair_ch),
        .i_cfg  (cfg_ch)
    );

    always #2 i_clk = ~i_clk;

    t_cfg        shadow_cfg = CFG_RESET;
    t_cmd        pending_cmds[$];
    t_pulse      expected_pulses[$];
    t_pulse      frame_buf[$];
    int unsigned frame_sum;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          error_count = 0;
    int          idle_cycles = 0;
    logic        cmd_taken = 1'b0;

    // ---------------- frame prediction ----------------
    function automatic void add_pulse(logic [US_W-1:0] mark, logic [US_W-1:0] space);
        t_pulse p;
        p.mark  = mark;
        p.space = space;
        p.last  = 1'b0;
        p.ftime = '0;
        if (frame_buf.size() < 64)
            frame_buf.push_back(p);
        frame_sum += mark + space;
        if (frame_sum > FRAME_TIME_MAX)
            frame_sum = FRAME_TIME_MAX;
    endfunction

    function automatic void add_timing(logic [31:0] timing);
        add_pulse(timing[31:16], timing[15:0]);
    endfunction

    function automatic void add_bit(logic b);
        add_timing(b ? shadow_cfg.one_timing : shadow_cfg.zero_timing);
    endfunction

    function automatic void add_seq(logic [SEQ_W-1:0] bits, int cnt, logic [1:0] order);
        int   pos;
        logic b;
        for (int k = 0; k < cnt; k++) begin
            pos = (order == ORD_PLAIN) ? k : cnt - 1 - k;
            b = bits[pos];
            if (order == ORD_INVREV)
                b = ~b;
            add_bit(b);
        end
    endfunction

    function automatic void add_trailer();
        if (shadow_cfg.options[OPT_TRL])
            add_pulse(shadow_cfg.options[23:8], '0);
    endfunction

    function automatic void build_frame(t_cmd c);
        logic [23:0]      opt;
        logic [SEQ_W-1:0] cmd_bits;
        int               clen;
        int               pcnt;
        int               scnt;
        opt = shadow_cfg.options;
        cmd_bits = {1'b0, c.bits};
        clen = c.len;
        pcnt = shadow_cfg.prefix_code[20:16];
        scnt = shadow_cfg.suffix_code[20:16];
        if (clen > MAX_COMMAND_BITS) clen = MAX_COMMAND_BITS;
        if (pcnt > MAX_PREFIX_BITS) pcnt = MAX_PREFIX_BITS;
        if (scnt > MAX_PREFIX_BITS) scnt = MAX_PREFIX_BITS;
        frame_buf.delete();
        frame_sum = 0;

        if (opt[OPT_RPT] && c.rep != 0) begin
            if (opt[OPT_RPT_HDR] && opt[OPT_HDR])
                add_timing(shadow_cfg.header_timing);
            add_timing(shadow_cfg.repeat_timing);
        end else if (opt[OPT_HEADLESS] && c.rep != 0) begin
            add_seq(shadow_cfg.prefix_code[15:0], pcnt, ORD_PLAIN);
            add_seq(cmd_bits, clen, ORD_PLAIN);
            add_seq(shadow_cfg.suffix_code[15:0], scnt, ORD_PLAIN);
        end else if (opt[OPT_TOGGLE] && c.rep[0]) begin
            // leading bits go out as they are, the rest inverted
            for (int k = 0; k < clen; k++)
                add_bit(k < TOGGLE_PLAIN_BITS ? cmd_bits[k] : ~cmd_bits[k]);
        end else begin
            if (opt[OPT_HDR])
                add_timing(shadow_cfg.header_timing);
            case (opt[7:6])
                FMT_NEC: begin
                    add_seq(shadow_cfg.prefix_code[15:0], pcnt, ORD_REV);
                    add_seq(shadow_cfg.prefix_code[15:0], pcnt, ORD_INVREV);
                    add_seq(cmd_bits, clen, ORD_REV);
                    add_seq(cmd_bits, clen, ORD_INVREV);
                end
                FMT_EXT: begin
                    add_seq(shadow_cfg.prefix_code[15:0], pcnt, ORD_REV);
                    add_seq(cmd_bits, clen, ORD_REV);
                    add_seq(cmd_bits, clen, ORD_INVREV);
                end
                default: begin
                    add_seq(shadow_cfg.prefix_code[15:0], pcnt, ORD_PLAIN);
                    add_seq(cmd_bits, clen, ORD_PLAIN);
                    add_seq(shadow_cfg.suffix_code[15:0], scnt, ORD_PLAIN);
                end
            endcase
        end
        add_trailer();

        if (frame_buf.size() > 0) begin
            frame_buf[frame_buf.size() - 1].last  = 1'b1;
            frame_buf[frame_buf.size() - 1].ftime = frame_sum[FT_W-1:0];
        end
        foreach (frame_buf[i])
            expected_pulses.push_back(frame_buf[i]);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // ---------------- driver ----------------
    always @(negedge i_clk) begin
        t_cmd nxt;
        if (!cmd_ch.valid || cmd_taken) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_cmds.pop_front();
                cmd_ch.valid          <= 1'b1;
                cmd_ch.command_bits   <= nxt.bits;
                cmd_ch.command_length <= nxt.len;
                cmd_ch.repetition     <= nxt.rep;
            end else begin
                cmd_ch.valid <= 1'b0;
            end
        end
        pair_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // ---------------- monitor, predictor hookup, watchdog ----------------
    always @(posedge i_clk) begin
        t_pulse want;
        logic   beat;
        beat = 1'b0;
        cmd_taken = cmd_ch.valid && cmd_ch.ready;
        if (i_rst_n) begin
            if (pair_ch.valid && pair_ch.ready) begin
                beat = 1'b1;
                if (expected_pulses.size() == 0) begin
                    $display("%0t: unexpected pair beat mark %0h space %0h last %0b",
                             $time, pair_ch.mark_us, pair_ch.space_us, pair_ch.last);
                    error_count++;
                end else begin
                    want = expected_pulses.pop_front();
                    check_field("mark_us", 32'(want.mark), 32'(pair_ch.mark_us));
                    check_field("space_us", 32'(want.space), 32'(pair_ch.space_us));
                    check_field("last", 32'(want.last), 32'(pair_ch.last));
                    check_field("frame_time_us", 32'(want.ftime), 32'(pair_ch.frame_time_us));
                end
            end
            // results of a command beat cannot show up on the edge that takes it
            if (cmd_taken) begin
                beat = 1'b1;
                build_frame('{cmd_ch.command_bits, cmd_ch.command_length, cmd_ch.repetition});
            end
            if (cfg_ch.valid && cfg_ch.ready)
                beat = 1'b1;
            idle_cycles = beat ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            REG_ZERO:   shadow_cfg.zero_timing   = val;
            REG_ONE:    shadow_cfg.one_timing    = val;
            REG_HEADER: shadow_cfg.header_timing = val;
            REG_REPEAT: shadow_cfg.repeat_timing = val;
            REG_OPT:    shadow_cfg.options       = val[23:0];
            REG_PREFIX: shadow_cfg.prefix_code   = val[20:0];
            REG_SUFFIX: shadow_cfg.suffix_code   = val[20:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [31:0] opt_word(logic hdr, logic trl, logic rpt, logic rpt_hdr,
                                             logic headless, logic toggle, logic [1:0] fmt,
                                             logic [15:0] trailer);
        logic [31:0] w;
        w = '0;
        w[OPT_HDR]      = hdr;
        w[OPT_TRL]      = trl;
        w[OPT_RPT]      = rpt;
        w[OPT_RPT_HDR]  = rpt_hdr;
        w[OPT_HEADLESS] = headless;
        w[OPT_TOGGLE]   = toggle;
        w[7:6]          = fmt;
        w[23:8]         = trailer;
        return w;
    endfunction

    function automatic void queue_cmd(logic [CMD_W-1:0] bits, logic [LEN_W-1:0] len,
                                      logic [REP_W-1:0] rep);
        pending_cmds.push_back('{bits, len, rep});
    endfunction

    // sender holds off until every command is taken and every pair is back, then lets an empty frame drain
    task automatic settle();
        while (pending_cmds.size() != 0 || cmd_ch.valid || expected_pulses.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_timing();
        if ($urandom_range(1))
            return $urandom;
        return {16'($urandom_range(100, 9000)), 16'($urandom_range(0, 9000))};
    endfunction

    task automatic randomize_config();
        write_reg(REG_ZERO, rand_timing());
        write_reg(REG_ONE, rand_timing());
        write_reg(REG_HEADER, rand_timing());
        write_reg(REG_REPEAT, rand_timing());
        write_reg(REG_OPT, $urandom & 32'h00FF_FFFF);
        write_reg(REG_PREFIX, {11'd0, 5'($urandom_range(0, 31)), 16'($urandom)});
        write_reg(REG_SUFFIX, {11'd0, 5'($urandom_range(0, 31)), 16'($urandom)});
    endtask

    function automatic logic [REP_W-1:0] rand_rep();
        int pick;
        pick = $urandom_range(9);
        if (pick < 4) return '0;
        if (pick < 7) return REP_W'($urandom_range(1, 3));
        return REP_W'($urandom);
    endfunction

    initial begin
        cmd_ch.valid          = 1'b0;
        cmd_ch.command_bits   = '0;
        cmd_ch.command_length = '0;
        cmd_ch.repetition     = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = '0;
        cfg_ch.data           = '0;
        pair_ch.ready         = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // defaults: standard NEC with header and trailer, repeat frames on
        queue_cmd('0, 4'd0, 8'd0);
        queue_cmd(15'h7FFF, 4'd15, 8'd0);
        queue_cmd(15'h1234, 4'd8, 8'd1);
        queue_cmd(15'h7FFF, 4'd15, 8'd255);
        settle();

        // repeat frame preceded by a header, zero repeat timing
        write_reg(REG_OPT, opt_word(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, FMT_NEC, 16'hFFFF));
        write_reg(REG_REPEAT, 32'h0000_0000);
        queue_cmd(15'h5555, 4'd15, 8'd1);
        queue_cmd(15'h2AAA, 4'd15, 8'd0);
        settle();

        // headless frames and a raw frame; suffix count above the limit is clamped
        write_reg(REG_PREFIX, 32'({5'd16, 16'hFFFF}));
        write_reg(REG_SUFFIX, 32'({5'd31, 16'hA5A5}));
        write_reg(REG_OPT, opt_word(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, FMT_RAW_B, 16'h0000));
        queue_cmd(15'h7FFF, 4'd15, 8'd2);
        queue_cmd(15'h0F0F, 4'd12, 8'd0);
        queue_cmd('0, 4'd0, 8'd1);
        settle();

        // toggle frames on odd repetitions, extended format otherwise
        write_reg(REG_OPT, opt_word(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, FMT_EXT, 16'h1234));
        write_reg(REG_PREFIX, 32'({5'd20, 16'h8001}));
        queue_cmd(15'h7FFF, 4'd15, 8'd1);
        queue_cmd('0, 4'd15, 8'd3);
        queue_cmd(15'h1234, 4'd15, 8'd2);
        queue_cmd(15'h0005, 4'd3, 8'd1);
        settle();

        // raw format: nothing to send gives an empty frame, then a full command follows
        write_reg(REG_OPT, opt_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FMT_RAW, 16'h0000));
        write_reg(REG_PREFIX, '0);
        write_reg(REG_SUFFIX, '0);
        queue_cmd(15'h7FFF, 4'd0, 8'd0);
        queue_cmd(15'h7FFF, 4'd0, 8'd5);
        queue_cmd(15'h4321, 4'd15, 8'd0);
        settle();

        // extreme timings and every option bit set
        write_reg(REG_ZERO, 32'h0000_0000);
        write_reg(REG_ONE, 32'hFFFF_FFFF);
        write_reg(REG_HEADER, 32'hFFFF_FFFF);
        write_reg(REG_REPEAT, 32'hFFFF_FFFF);
        write_reg(REG_OPT, 32'h00FF_FFFF);
        write_reg(REG_PREFIX, 32'h001F_FFFF);
        write_reg(REG_SUFFIX, 32'h001F_FFFF);
        queue_cmd(15'h7FFF, 4'd15, 8'd0);
        queue_cmd('0, 4'd15, 8'd0);
        queue_cmd(15'h7FFF, 4'd15, 8'd7);
        settle();

        // longest frame: 64 pairs
        write_reg(REG_ZERO, 32'hFFFF_FFFF);
        write_reg(REG_OPT, opt_word(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, FMT_NEC, 16'hFFFF));
        queue_cmd(15'h2AAA, 4'd15, 8'd0);
        settle();

        // random part: no idling, sender idle, receiver stalls, both
        for (int mode = 0; mode < 4; mode++) begin
            send_idle_pct = (mode == 1) ? 64 : (mode == 3) ? 12 : 0;
            stall_pct     = (mode == 2) ? 64 : (mode == 3) ? 12 : 0;
            for (int grp = 0; grp < 3; grp++) begin
                randomize_config();
                for (int n = 0; n < 9; n++)
                    queue_cmd(CMD_W'($urandom), LEN_W'($urandom_range(0, 15)), rand_rep());
                settle();
            end
        end

        repeat (2 * DRAIN_GAP) @(posedge i_clk);
        if (error_count == 0 && expected_pulses.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/irpd_pkg.sv
rtl/irpd_if.sv
rtl/irpd_cfg.sv
rtl/irpd_plan.sv
rtl/irpd_seq.sv
rtl/irpd_acc.sv
rtl/ir_pulse_distance_frame_encoder.sv
sim/ir_pulse_distance_frame_encoder_test.sv
